// ----- rtl/kfti_pkg.sv -----
// Shared types and constants for the keyframe track interpolator.
`timescale 1ns / 1ps
package kfti_pkg;

  localparam int MAX_KEYS_DEF = 64;
  localparam int TIME_W       = 24;
  localparam int VEC_W        = 32;
  localparam int CNT_W        = 7;
  localparam int IDX_W        = 6;
  localparam int NUM_W        = TIME_W + 1;
  localparam int DIFF_W       = VEC_W + 1;
  localparam int PROD_W       = DIFF_W + NUM_W;
  localparam int MAG_W        = PROD_W - 1;
  localparam int SUM_W        = MAG_W + 2;
  localparam int IN_DATA_W    = 248;
  localparam int OUT_DATA_W   = 200;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_LAST_ZERO = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_WR, S_LRD, S_LCHK, S_MOD, S_SRD, S_SCMP, S_TARD, S_TBRD,
    S_DEN, S_VA, S_VB, S_MUL, S_DST, S_DIV, S_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

// ----- rtl/keyframe_track_interpolator_core.sv -----
// Top level of the keyframe track interpolator: key tables, sequencer and blend path.
`timescale 1ns / 1ps
//  Channel | Direction | Handshake              | Word
//  in_     | slave     | in_tvalid / in_tready  | in_tuser req_type, in_tdata key fields
//  out_    | master    | out_tvalid / out_tready| out_tdata status and six vectors
//  cfg_    | slave     | cfg_valid / cfg_ready  | cfg_data key_count
// A write word updates one key slot. A query with two or more keys in use wraps the query
// time by the last key time (unless that is zero), searches the keys, fetches the bounding
// keys and blends the six components in turn (without division when the keys share a time
// or only one key is in use) and loads the result, using the single shared serial divider.
// Reset is synchronous; the key tables hold no reset value.
// A finished result waits in the output register while the next word is accepted.
module keyframe_track_interpolator_core #(
  parameter int MAX_KEYS = kfti_pkg::MAX_KEYS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // req_type
  input  logic [0:0]                        in_tuser,
  // key_index, key_time, pos_x, pos_y, pos_z, scale_x, scale_y, scale_z, query_time
  input  logic [kfti_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // status, out_pos_x, out_pos_y, out_pos_z, out_scale_x, out_scale_y, out_scale_z
  output logic [kfti_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kfti_pkg::CNT_W-1:0]        cfg_data
);
  localparam int KIW = $clog2(MAX_KEYS);
  localparam int VAW = $clog2(3 * MAX_KEYS);
  localparam int NW  = $clog2(MAX_KEYS + 1);
  localparam int TW  = kfti_pkg::TIME_W;
  localparam int VW  = kfti_pkg::VEC_W;

  kfti_pkg::state_t state_r, state_nxt;

  logic [kfti_pkg::CNT_W-1:0] key_count_r;
  logic [TW-1:0] tmem [MAX_KEYS];
  logic [VW-1:0] pmem [3*MAX_KEYS];
  logic [VW-1:0] smem [3*MAX_KEYS];
  logic [TW-1:0] t_rd_r;
  logic [VW-1:0] p_rd_r, s_rd_r;
  logic [KIW-1:0] t_addr;
  logic [VAW-1:0] v_addr, w_addr;
  logic           t_we, v_we, k_ok;

  logic [kfti_pkg::IN_DATA_W-1:0] item_r;
  logic [NW-1:0]  n_r;
  logic [KIW-1:0] s_r, i_r;
  logic [2:0]     cnt_r;
  logic           copy_r;
  logic [TW-1:0]  last_r, w_r, ta_r;
  logic signed [kfti_pkg::NUM_W-1:0]  num_r, den_r;
  logic signed [VW-1:0]               va_r, vb;
  logic signed [kfti_pkg::PROD_W-1:0] p_r;
  logic [VW-1:0]  res_r [6];
  logic [1:0]     status_r;
  logic           out_valid_r;
  logic [kfti_pkg::OUT_DATA_W-1:0] out_data_r;

  logic [31:0] n32, k32;
  logic [1:0]  sub;
  logic [31:0] base32;

  logic                        div_start;
  logic [kfti_pkg::MAG_W-1:0]  div_dvd, div_q;
  logic [TW-1:0]               div_dvs, div_rem;
  kfti_pkg::div_ctl_t          div_ctl;

  logic signed [kfti_pkg::SUM_W-1:0] q_s, r_s;
  logic signed [VW-1:0]              r_sat;

  kfti_div #(.DW(kfti_pkg::MAG_W), .VW(TW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd),
    .divisor(div_dvs), .ctl(div_ctl), .quot(div_q), .rem(div_rem)
  );

  assign k32  = {26'd0, item_r[5:0]};
  assign k_ok = k32 < MAX_KEYS;
  assign sub  = (cnt_r < 3'd3) ? cnt_r[1:0] : 2'(cnt_r - 3'd3);
  assign vb   = (cnt_r < 3'd3) ? p_rd_r : s_rd_r;
  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == kfti_pkg::S_IDLE);

  always_comb begin
    logic [31:0] kq;
    kq  = {25'd0, key_count_r};
    n32 = (kq > MAX_KEYS) ? MAX_KEYS : kq;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kfti_pkg::S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser[0] == kfti_pkg::REQ_WRITE) state_nxt = kfti_pkg::S_WR;
          else if (n32 == 0) state_nxt = kfti_pkg::S_OUT;
          else if (n32 == 1) state_nxt = kfti_pkg::S_VA;
          else state_nxt = kfti_pkg::S_LRD;
        end
      end
      kfti_pkg::S_WR:   if (cnt_r == 3'd2) state_nxt = kfti_pkg::S_IDLE;
      kfti_pkg::S_LRD:  state_nxt = kfti_pkg::S_LCHK;
      kfti_pkg::S_LCHK: state_nxt = (t_rd_r == '0) ? kfti_pkg::S_OUT : kfti_pkg::S_MOD;
      kfti_pkg::S_MOD:  if (div_ctl.done) state_nxt = kfti_pkg::S_SRD;
      kfti_pkg::S_SRD:  state_nxt = kfti_pkg::S_SCMP;
      kfti_pkg::S_SCMP: begin
        if (w_r < t_rd_r || NW'(s_r) == n_r - NW'(2)) state_nxt = kfti_pkg::S_TARD;
        else state_nxt = kfti_pkg::S_SRD;
      end
      kfti_pkg::S_TARD: state_nxt = kfti_pkg::S_TBRD;
      kfti_pkg::S_TBRD: state_nxt = kfti_pkg::S_DEN;
      kfti_pkg::S_DEN:  state_nxt = kfti_pkg::S_VA;
      kfti_pkg::S_VA:   state_nxt = kfti_pkg::S_VB;
      kfti_pkg::S_VB:   state_nxt = kfti_pkg::S_MUL;
      kfti_pkg::S_MUL: begin
        if (copy_r || den_r <= 0) state_nxt = (cnt_r == 3'd5) ? kfti_pkg::S_OUT
                                                              : kfti_pkg::S_VA;
        else state_nxt = kfti_pkg::S_DST;
      end
      kfti_pkg::S_DST:  state_nxt = kfti_pkg::S_DIV;
      kfti_pkg::S_DIV: begin
        if (div_ctl.done) state_nxt = (cnt_r == 3'd5) ? kfti_pkg::S_OUT : kfti_pkg::S_VA;
      end
      kfti_pkg::S_OUT:  if (!out_valid_r) state_nxt = kfti_pkg::S_IDLE;
      default:          state_nxt = kfti_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer: table addresses, writes, divider start and divider operands.
  always_comb begin
    t_addr    = s_r + KIW'(1);
    v_addr    = '0;
    t_we      = 1'b0;
    v_we      = 1'b0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    base32    = 32'(i_r) * 3;
    w_addr    = VAW'(k32 * 3 + {30'd0, cnt_r[1:0]});
    case (state_r)
      kfti_pkg::S_WR: begin
        t_we = k_ok;
        v_we = k_ok;
      end
      kfti_pkg::S_LRD:  t_addr = KIW'(n_r - NW'(1));
      kfti_pkg::S_LCHK: begin
        div_start = (t_rd_r != '0);
        div_dvd   = kfti_pkg::MAG_W'(item_r[245:222]);
        div_dvs   = t_rd_r;
      end
      kfti_pkg::S_TARD: t_addr = i_r;
      kfti_pkg::S_TBRD: t_addr = i_r + KIW'(1);
      kfti_pkg::S_VA:   v_addr = VAW'(base32 + {30'd0, sub});
      kfti_pkg::S_VB:   v_addr = VAW'(base32 + 32'd3 + {30'd0, sub});
      kfti_pkg::S_DST: begin
        div_start = 1'b1;
        div_dvd   = p_r[kfti_pkg::PROD_W-1] ? kfti_pkg::MAG_W'(-p_r)
                                             : kfti_pkg::MAG_W'(p_r);
        div_dvs   = TW'(den_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    q_s = p_r[kfti_pkg::PROD_W-1]
        ? -(kfti_pkg::SUM_W'(div_q) + kfti_pkg::SUM_W'(div_rem != '0))
        : kfti_pkg::SUM_W'(div_q);
    r_s = kfti_pkg::SUM_W'(va_r) + q_s;
    if (r_s > kfti_pkg::SUM_W'(32'sh7fffffff)) r_sat = 32'sh7fffffff;
    else if (r_s < -kfti_pkg::SUM_W'(64'sh80000000)) r_sat = 32'sh80000000;
    else r_sat = VW'(r_s);
  end

  always_ff @(posedge clk) begin
    if (t_we) tmem[KIW'(k32)] <= item_r[29:6];
    if (v_we) begin
      case (cnt_r[1:0])
        2'd0: begin
          pmem[w_addr] <= item_r[61:30];
          smem[w_addr] <= item_r[157:126];
        end
        2'd1: begin
          pmem[w_addr] <= item_r[93:62];
          smem[w_addr] <= item_r[189:158];
        end
        default: begin
          pmem[w_addr] <= item_r[125:94];
          smem[w_addr] <= item_r[221:190];
        end
      endcase
    end
    t_rd_r <= tmem[t_addr];
    p_rd_r <= pmem[v_addr];
    s_rd_r <= smem[v_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kfti_pkg::S_IDLE;
      key_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) key_count_r <= cfg_data;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      else if (state_r == kfti_pkg::S_OUT) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      kfti_pkg::S_IDLE: begin
        item_r   <= in_tdata;
        n_r      <= NW'(n32);
        cnt_r    <= '0;
        s_r      <= '0;
        i_r      <= '0;
        copy_r   <= (n32 == 1);
        status_r <= (n32 == 0) ? kfti_pkg::ST_EMPTY : kfti_pkg::ST_OK;
        for (int j = 0; j < 6; j++) res_r[j] <= '0;
      end
      kfti_pkg::S_WR:   cnt_r <= cnt_r + 3'd1;
      kfti_pkg::S_LCHK: begin
        last_r <= t_rd_r;
        if (t_rd_r == '0) status_r <= kfti_pkg::ST_LAST_ZERO;
      end
      kfti_pkg::S_MOD:  if (div_ctl.done) w_r <= div_rem;
      kfti_pkg::S_SCMP: begin
        if (w_r < t_rd_r || NW'(s_r) == n_r - NW'(2)) i_r <= s_r;
        else s_r <= s_r + KIW'(1);
      end
      kfti_pkg::S_TBRD: ta_r <= t_rd_r;
      kfti_pkg::S_DEN: begin
        num_r <= kfti_pkg::NUM_W'(w_r) - kfti_pkg::NUM_W'(ta_r);
        den_r <= kfti_pkg::NUM_W'(t_rd_r) - kfti_pkg::NUM_W'(ta_r);
      end
      kfti_pkg::S_VB:   va_r <= vb;
      kfti_pkg::S_MUL: begin
        p_r <= (kfti_pkg::DIFF_W'(vb) - kfti_pkg::DIFF_W'(va_r)) * num_r;
        if (copy_r || den_r <= 0) begin
          res_r[cnt_r] <= va_r;
          cnt_r        <= cnt_r + 3'd1;
        end
      end
      kfti_pkg::S_DIV: begin
        if (div_ctl.done) begin
          res_r[cnt_r] <= r_sat;
          cnt_r        <= cnt_r + 3'd1;
        end
      end
      kfti_pkg::S_OUT: begin
        if (!out_valid_r) begin
          out_data_r <= {6'd0, res_r[5], res_r[4], res_r[3], res_r[2], res_r[1],
                         res_r[0], status_r};
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready) else $error("word accepted while busy");
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[1:0] == kfti_pkg::ST_EMPTY) |-> (out_data_r[193:2] == '0))
    else $error("empty-table result carries data");
  a_div_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.busy |-> (state_r == kfti_pkg::S_MOD || state_r == kfti_pkg::S_DIV))
    else $error("divider running outside a query");
  a_wrap_below_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kfti_pkg::S_SRD) |-> (w_r < last_r)) else $error("wrapped time too large");
endmodule

// ----- rtl/kfti_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module kfti_div #(
  parameter int DW = kfti_pkg::MAG_W,
  parameter int VW = kfti_pkg::TIME_W
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [DW-1:0]             dividend,
  input  logic [VW-1:0]             divisor,
  output kfti_pkg::div_ctl_t        ctl,
  output logic [DW-1:0]             quot,
  output logic [VW-1:0]             rem
);
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] q_r, q_nxt;
  logic [VW:0]   rem_r, rem_nxt;
  logic [VW-1:0] dvs_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [VW:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[VW-1:0], q_r[DW-1]};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        q_nxt   = {q_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign ctl.start = start;
  assign ctl.busy  = busy_r;
  assign ctl.done  = done_r;
  assign quot      = q_r;
  assign rem       = rem_r[VW-1:0];

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start) else $error("divider restarted while busy");
  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < {1'b0, dvs_r})) else $error("remainder not below divisor");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("done without a running division");
endmodule

// ----- dv/keyframe_track_interpolator_core_test.sv -----
// Self-checking testbench for the keyframe track interpolator core.
`timescale 1ns / 1ps
module keyframe_track_interpolator_core_test;

  typedef enum {ROW_CFG, ROW_KEY, ROW_ASK} row_kind_t;

  typedef struct packed {
    kfti_pkg::status_t st;
    logic [5:0][31:0]  vec;
  } sample_t;

  typedef struct {
    row_kind_t        kind;
    logic [6:0]       count;
    logic [5:0]       slot;
    logic [23:0]      ktime;
    logic [5:0][31:0] vec;
    logic [23:0]      qtime;
    bit               typed;
    sample_t          want;
  } row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [0:0]                      in_tuser = kfti_pkg::REQ_WRITE;
  logic [kfti_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [kfti_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [kfti_pkg::CNT_W-1:0]      cfg_data = '0;

  logic [6:0]       count_m;
  logic [23:0]      time_m [64];
  logic [5:0][31:0] vec_m  [64];
  sample_t          samples_due [$];
  int               send_gap_pct;
  int               stall_pct;
  int               hold_left;
  int               mismatches;
  row_t             rows [$];

  keyframe_track_interpolator_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [31:0] lerp(logic [31:0] va, logic [31:0] vb, longint num,
                                       longint den);
    longint a, b, r, p, q;
    a = longint'($signed(va));
    b = longint'($signed(vb));
    r = a;
    if (den > 0) begin
      p = (b - a) * num;
      q = p / den;
      if ((p % den) != 0 && p < 0) q--;
      r = a + q;
    end
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic sample_t interpolate(logic [23:0] qtime);
    sample_t s;
    int n, i;
    logic [23:0] w;
    s = '{st: kfti_pkg::ST_OK, vec: '0};
    n = (count_m > 64) ? 64 : count_m;
    if (n == 0) begin
      s.st = kfti_pkg::ST_EMPTY;
    end else if (n == 1) begin
      s.vec = vec_m[0];
    end else if (time_m[n-1] == 0) begin
      s.st = kfti_pkg::ST_LAST_ZERO;
    end else begin
      w = qtime % time_m[n-1];
      i = n - 2;
      for (int k = 0; k + 1 < n; k++) begin
        if (w < time_m[k+1]) begin
          i = k;
          break;
        end
      end
      for (int j = 0; j < 6; j++)
        s.vec[j] = lerp(vec_m[i][j], vec_m[i+1][j], longint'(w) - longint'(time_m[i]),
                        longint'(time_m[i+1]) - longint'(time_m[i]));
    end
    return s;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    sample_t got, exp_s;
    if (rst_n && out_tvalid && out_tready) begin
      got.st = kfti_pkg::status_t'(out_tdata[1:0]);
      for (int j = 0; j < 6; j++) got.vec[j] = out_tdata[2+32*j +: 32];
      if (samples_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word %h", out_tdata);
      end else begin
        exp_s = samples_due.pop_front();
        if (got !== exp_s) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected status %0d vec %h, got status %0d vec %h",
                     exp_s.st, exp_s.vec, got.st, got.vec);
        end
      end
    end
  end

  task automatic drain();
    in_tvalid <= 1'b0;
    while (samples_due.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  task automatic set_count(logic [6:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    count_m = value;
  endtask

  task automatic send_word(logic req, logic [5:0] slot, logic [23:0] ktime,
                           logic [5:0][31:0] vec, logic [23:0] qtime, bit typed,
                           sample_t want);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {2'b00, qtime, vec, ktime, slot};
    do @(posedge clk); while (!in_tready);
    if (req == kfti_pkg::REQ_WRITE) begin
      time_m[slot] = ktime;
      vec_m[slot]  = vec;
    end else begin
      samples_due.push_back(typed ? want : interpolate(qtime));
    end
    if ($urandom_range(0, 99) < send_gap_pct) begin
      gap = $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_vec();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [5:0][31:0] rand_vecs();
    logic [5:0][31:0] v;
    for (int j = 0; j < 6; j++) v[j] = rand_vec();
    return v;
  endfunction

  function automatic row_t mk(row_kind_t kind, int count, int slot, int ktime,
                              logic [5:0][31:0] vec, int qtime, bit typed, sample_t want);
    row_t r;
    r = '{kind, 7'(count), 6'(slot), 24'(ktime), vec, 24'(qtime), typed, want};
    return r;
  endfunction

  initial begin
    logic [5:0][31:0] v0, v1, v2;
    sample_t zero_s, empty_s, lastz_s, key0_s;
    int n, step, items_done, gap_sel;
    logic [23:0] t;
    row_t r;

    v0 = {32'h1234_5678, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF};
    v1 = {32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF,
          32'h8000_0000};
    v2 = {32'hDEAD_BEEF, 32'h0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_8000, 32'hFFFF_8000};
    zero_s  = '{st: kfti_pkg::ST_OK, vec: '0};
    empty_s = '{st: kfti_pkg::ST_EMPTY, vec: '0};
    lastz_s = '{st: kfti_pkg::ST_LAST_ZERO, vec: '0};
    key0_s  = '{st: kfti_pkg::ST_OK, vec: v0};

    rows.push_back(mk(ROW_ASK, 0, 0, 0, '0, 24'hFFFFFF, 1, empty_s));
    rows.push_back(mk(ROW_KEY, 0, 0, 0, v0, 0, 0, zero_s));
    rows.push_back(mk(ROW_CFG, 1, 0, 0, '0, 0, 0, zero_s));
    rows.push_back(mk(ROW_ASK, 0, 0, 0, '0, 12345, 1, key0_s));
    rows.push_back(mk(ROW_KEY, 0, 1, 0, v1, 0, 0, zero_s));
    rows.push_back(mk(ROW_CFG, 2, 0, 0, '0, 0, 0, zero_s));
    rows.push_back(mk(ROW_ASK, 0, 0, 0, '0, 77, 1, lastz_s));
    rows.push_back(mk(ROW_KEY, 0, 1, 24'hFFFFFF, v1, 0, 0, zero_s));
    rows.push_back(mk(ROW_ASK, 0, 0, 0, '0, 24'hFFFFFF, 1, key0_s));
    rows.push_back(mk(ROW_ASK, 0, 0, 0, '0, 24'h7FFFFF, 0, zero_s));
    rows.push_back(mk(ROW_ASK, 0, 0, 0, '0, 24'hFFFFFE, 0, zero_s));
    rows.push_back(mk(ROW_KEY, 0, 2, 100, v2, 0, 0, zero_s));
    rows.push_back(mk(ROW_CFG, 3, 0, 0, '0, 0, 0, zero_s));
    rows.push_back(mk(ROW_ASK, 0, 0, 0, '0, 50, 0, zero_s));
    rows.push_back(mk(ROW_ASK, 0, 0, 0, '0, 199, 0, zero_s));
    rows.push_back(mk(ROW_KEY, 0, 0, 60, v0, 0, 0, zero_s));
    rows.push_back(mk(ROW_ASK, 0, 0, 0, '0, 30, 0, zero_s));
    rows.push_back(mk(ROW_KEY, 0, 1, 60, v1, 0, 0, zero_s));
    rows.push_back(mk(ROW_ASK, 0, 0, 0, '0, 60, 0, zero_s));
    rows.push_back(mk(ROW_KEY, 0, 63, 24'hFFFFFF, v2, 0, 0, zero_s));

    mismatches = 0;
    hold_left = 0;
    send_gap_pct = 0;
    stall_pct = 0;
    count_m = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[k]) begin
      r = rows[k];
      case (r.kind)
        ROW_CFG: set_count(r.count);
        ROW_KEY: send_word(kfti_pkg::REQ_WRITE, r.slot, r.ktime, r.vec, r.qtime, 0, r.want);
        default: send_word(kfti_pkg::REQ_QUERY, r.slot, r.ktime, r.vec, r.qtime, r.typed,
                           r.want);
      endcase
    end

    items_done = 0;
    for (int ph = 0; ph < 10; ph++) begin
      gap_sel = ph % 4;
      send_gap_pct = (gap_sel == 1) ? 49 : (gap_sel == 3) ? 10 : 0;
      stall_pct    = (gap_sel == 2) ? 49 : (gap_sel == 3) ? 10 : 0;
      case (ph)
        0: n = 64;
        1: n = 1;
        2: n = 2;
        3: n = 127;
        4: n = 0;
        default: n = $urandom_range(2, 12);
      endcase
      t = 0;
      step = 24'hFFFFFF / ((n == 0) ? 1 : (n > 64 ? 64 : n));
      for (int k = 0; k < 64 && k < n; k++) begin
        if ($urandom_range(0, 9) != 0) t = t + 24'($urandom_range(0, step - 1));
        send_word(kfti_pkg::REQ_WRITE, 6'(k), t, rand_vecs(), 24'($urandom), 0, zero_s);
      end
      set_count(7'(n));
      if (ph == 6) hold_left = 3000;
      for (int k = 0; k < 100; k++) begin
        if (n != 0 && $urandom_range(0, 9) < 2)
          send_word(kfti_pkg::REQ_WRITE, 6'($urandom_range(0, (n > 64 ? 64 : n) - 1)),
                    ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                : time_m[$urandom_range(0, 1)],
                    rand_vecs(), 24'($urandom), 0, zero_s);
        else
          send_word(kfti_pkg::REQ_QUERY, 6'($urandom), 24'($urandom),
                    rand_vecs(),
                    ($urandom_range(0, 1) == 0) ? 24'($urandom)
                                                : 24'($urandom_range(0, t + 1)),
                    0, zero_s);
        items_done++;
      end
    end
    drain();
    if (mismatches == 0 && samples_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- keyframe_track_interpolator_core.f -----
rtl/kfti_pkg.sv
rtl/kfti_div.sv
rtl/keyframe_track_interpolator_core.sv
dv/keyframe_track_interpolator_core_test.sv
